>>> rtl/ccie_pkg.sv
// ----------------------------------------------------------------------------
// ccie_pkg: shared definitions for the coprime counter
// Widths, the prime list capacity and the request and response bundles that
// pass between the sequencer and the serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

package ccie_pkg;

  // Width of the limit, the modulus and the result.
  localparam int unsigned DATA_W = 32;

  // Capacity of the prime list. Nine distinct primes cover any 32-bit modulus.
  localparam int unsigned MAX_DISTINCT_PRIMES = 9;

  // Prime count (holds 0 to the capacity) and prime list index.
  localparam int unsigned CNT_W = $clog2(MAX_DISTINCT_PRIMES + 1);
  localparam int unsigned IDX_W = (MAX_DISTINCT_PRIMES > 1) ?
                                  $clog2(MAX_DISTINCT_PRIMES) : 1;

  // Subset mask, wide enough to hold one past the last subset.
  localparam int unsigned MASK_W = MAX_DISTINCT_PRIMES + 1;

  // Trial divisor stops at 2^16 at most; its square needs one extra bit.
  localparam int unsigned TRIAL_W = DATA_W / 2 + 1;
  localparam int unsigned SQ_W    = DATA_W + 1;

  // Signed accumulator: partial sums stay within a few times the limit.
  localparam int unsigned ACC_W = DATA_W + 4;

  // Divider iteration counter.
  localparam int unsigned DIV_CNT_W = $clog2(DATA_W);

  // Request to the serial divider.
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  // Response from the serial divider.
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/ccie_div.sv
// ----------------------------------------------------------------------------
// ccie_div: serial unsigned divider
// Restoring division, one quotient bit per cycle. A start loads the operands;
// the done pulse comes with quotient and remainder after the last iteration.
// ----------------------------------------------------------------------------
`default_nettype none

module ccie_div (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire ccie_pkg::div_req_t  req_i,
  output ccie_pkg::div_rsp_t       rsp_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [ccie_pkg::DIV_CNT_W-1:0]      cnt_q;
  logic [ccie_pkg::DATA_W-1:0]         quo_q;
  logic [ccie_pkg::DATA_W-1:0]         rem_q;
  logic [ccie_pkg::DATA_W-1:0]         div_q;
  logic [ccie_pkg::DATA_W:0]           shifted;
  logic [ccie_pkg::DATA_W:0]           diff;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    shifted = {rem_q, quo_q[ccie_pkg::DATA_W-1]};
    diff    = shifted - {1'b0, div_q};
  end

  // Iteration control and datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else begin
      // The done pulse follows the last iteration.
      done_q <= !req_i.start && busy_q &&
                (cnt_q == ccie_pkg::DIV_CNT_W'(ccie_pkg::DATA_W - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        quo_q  <= req_i.dividend;
        rem_q  <= '0;
        div_q  <= req_i.divisor;
      end else if (busy_q) begin
        if (!diff[ccie_pkg::DATA_W]) begin
          rem_q <= diff[ccie_pkg::DATA_W-1:0];
          quo_q <= {quo_q[ccie_pkg::DATA_W-2:0], 1'b1};
        end else begin
          rem_q <= shifted[ccie_pkg::DATA_W-1:0];
          quo_q <= {quo_q[ccie_pkg::DATA_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ccie_pkg::DIV_CNT_W'(ccie_pkg::DATA_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

>>> rtl/coprime_count_inclusion_exclusion.sv
// Work per item: one division per trial divisor up to the square root of the
// remaining modulus, one more per factor found, and for each prime subset one
// product step per listed prime and one division. One item at a time, on the one
// serial 32-bit divider: a new item is taken only once the sequencer is idle.
// Reset (rst_ni, asynchronous, active low) returns the sequencer to idle and
// empties the result register.
// ----------------------------------------------------------------------------
// coprime_count_inclusion_exclusion: count of 1..n coprime to m
// Finds the distinct primes of m by trial division, then sums n / d over all
// prime subsets with alternating sign, on one shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module coprime_count_inclusion_exclusion (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [ccie_pkg::DATA_W-1:0] limit_n_i,
  input  wire logic [ccie_pkg::DATA_W-1:0] modulus_m_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic [ccie_pkg::DATA_W-1:0] coprime_count_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRIAL_CHK,
    S_DIV_WAIT,
    S_TAIL,
    S_SUB_INIT,
    S_SUB_MUL,
    S_SUB_DIV,
    S_FINISH
  } state_e;

  state_e                                state_q;
  logic [ccie_pkg::DATA_W-1:0]           n_q;
  logic [ccie_pkg::DATA_W-1:0]           m_q;
  logic [ccie_pkg::TRIAL_W-1:0]          d_q;
  logic [ccie_pkg::SQ_W-1:0]             sq_q;
  logic                                  found_q;
  logic [ccie_pkg::CNT_W-1:0]            cnt_q;
  logic [ccie_pkg::DATA_W-1:0]           primes_q [ccie_pkg::MAX_DISTINCT_PRIMES];
  logic [ccie_pkg::MASK_W-1:0]           mask_q;
  logic [ccie_pkg::CNT_W-1:0]            idx_q;
  logic [ccie_pkg::DATA_W-1:0]           prod_q;
  logic                                  par_q;
  logic signed [ccie_pkg::ACC_W-1:0]     acc_q;
  logic                                  out_valid_q;
  logic [ccie_pkg::DATA_W-1:0]           out_data_q;

  ccie_pkg::div_req_t                    div_req;
  ccie_pkg::div_rsp_t                    div_rsp;
  logic [ccie_pkg::MASK_W-1:0]           full;
  logic [ccie_pkg::DATA_W-1:0]           d_ext;
  logic [ccie_pkg::DATA_W-1:0]           prime_sel;
  logic [2*ccie_pkg::DATA_W-1:0]         mul_full;
  logic signed [ccie_pkg::ACC_W-1:0]     quo_ext;
  logic                                  can_cap;
  logic                                  out_free;

  // Shared serial divider.
  ccie_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Helper values for the sequencer.
  always_comb begin
    full      = ccie_pkg::MASK_W'(1) << cnt_q;
    d_ext     = ccie_pkg::DATA_W'(d_q);
    prime_sel = primes_q[idx_q[ccie_pkg::IDX_W-1:0]];
    mul_full  = prod_q * prime_sel;
    quo_ext   = $signed({{(ccie_pkg::ACC_W - ccie_pkg::DATA_W){1'b0}}, div_rsp.quotient});
    can_cap   = (cnt_q < ccie_pkg::CNT_W'(ccie_pkg::MAX_DISTINCT_PRIMES));
    out_free  = !out_valid_q || !out_stall_i;
  end

  // Divider requests: trial check, repeated factor removal, subset term.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = m_q;
    div_req.divisor  = d_ext;
    unique case (state_q)
      S_TRIAL_CHK: begin
        div_req.start = (sq_q <= {1'b0, m_q});
      end
      S_DIV_WAIT: begin
        div_req.start    = div_rsp.done && (div_rsp.remainder == '0);
        div_req.dividend = div_rsp.quotient;
      end
      S_SUB_MUL: begin
        div_req.start    = (idx_q == cnt_q);
        div_req.dividend = n_q;
        div_req.divisor  = prod_q;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // Sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      m_q         <= '0;
      d_q         <= '0;
      sq_q        <= '0;
      found_q     <= 1'b0;
      cnt_q       <= '0;
      primes_q    <= '{default: '0};
      mask_q      <= '0;
      idx_q       <= '0;
      prod_q      <= '0;
      par_q       <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // A taken result empties the register unless a new one lands now.
      if (out_valid_q && !out_stall_i && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            n_q     <= limit_n_i;
            m_q     <= modulus_m_i;
            d_q     <= ccie_pkg::TRIAL_W'(2);
            sq_q    <= ccie_pkg::SQ_W'(4);
            cnt_q   <= '0;
            found_q <= 1'b0;
            state_q <= S_TRIAL_CHK;
          end
        end
        S_TRIAL_CHK: begin
          if (sq_q <= {1'b0, m_q}) begin
            state_q <= S_DIV_WAIT;
          end else begin
            state_q <= S_TAIL;
          end
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            if (div_rsp.remainder == '0) begin
              // The divisor is a factor: record it once, then keep dividing.
              if (!found_q && can_cap) begin
                primes_q[cnt_q[ccie_pkg::IDX_W-1:0]] <= d_ext;
                cnt_q <= cnt_q + 1'b1;
              end
              found_q <= 1'b1;
              m_q     <= div_rsp.quotient;
            end else begin
              found_q <= 1'b0;
              sq_q    <= sq_q + {d_q, 1'b1};
              d_q     <= d_q + 1'b1;
              state_q <= S_TRIAL_CHK;
            end
          end
        end
        S_TAIL: begin
          // A remainder above one is the last prime.
          if ((m_q > ccie_pkg::DATA_W'(1)) && can_cap) begin
            primes_q[cnt_q[ccie_pkg::IDX_W-1:0]] <= m_q;
            cnt_q <= cnt_q + 1'b1;
          end
          acc_q   <= $signed({{(ccie_pkg::ACC_W - ccie_pkg::DATA_W){1'b0}}, n_q});
          mask_q  <= ccie_pkg::MASK_W'(1);
          state_q <= S_SUB_INIT;
        end
        S_SUB_INIT: begin
          if (mask_q == full) begin
            state_q <= S_FINISH;
          end else begin
            prod_q  <= ccie_pkg::DATA_W'(1);
            idx_q   <= '0;
            par_q   <= 1'b0;
            state_q <= S_SUB_MUL;
          end
        end
        S_SUB_MUL: begin
          // One prime of the list per cycle; those in the subset go into the running product.
          if (idx_q == cnt_q) begin
            state_q <= S_SUB_DIV;
          end else begin
            if (mask_q[idx_q]) begin
              prod_q <= mul_full[ccie_pkg::DATA_W-1:0];
              par_q  <= !par_q;
            end
            idx_q <= idx_q + 1'b1;
          end
        end
        S_SUB_DIV: begin
          if (div_rsp.done) begin
            if (par_q) begin
              acc_q <= acc_q - quo_ext;
            end else begin
              acc_q <= acc_q + quo_ext;
            end
            mask_q  <= mask_q + 1'b1;
            state_q <= S_SUB_INIT;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= acc_q[ccie_pkg::ACC_W-1] ? '0 : acc_q[ccie_pkg::DATA_W-1:0];
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign coprime_count_o = out_data_q;

`ifndef SYNTHESIS
  // An accepted item makes the block busy on the next cycle.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after an accepted item");

  // The prime list never overflows its capacity.
  a_cnt_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ccie_pkg::CNT_W'(ccie_pkg::MAX_DISTINCT_PRIMES))
    else $error("prime count above capacity");

  // Divider results arrive only while the sequencer waits for them.
  a_done_expected : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV_WAIT || state_q == S_SUB_DIV))
    else $error("divider result while not waiting");

  // A new result never exceeds the limit of its item.
  a_result_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && out_free) |=> (coprime_count_o <= n_q))
    else $error("result above limit");
`endif

endmodule

`default_nettype wire

>>> verif/coprime_count_inclusion_exclusion_tb.sv
// ----------------------------------------------------------------------------
// coprime_count_inclusion_exclusion_tb: self-checking bench for the counter
// Sends limit and modulus items, predicts each coprime count by trial division
// and an alternating prime subset sum, or a pinned row's count; compares all in order.
// ----------------------------------------------------------------------------
module coprime_count_inclusion_exclusion_tb;

  typedef logic [ccie_pkg::DATA_W-1:0] word_t;

  // One row of the directed table. When pinned, count is the typed-in answer.
  typedef struct {
    word_t limit_n;
    word_t modulus_m;
    bit    pinned;
    word_t count;
  } stim_row_t;

  // Typed-in answer that travels with an item until the block accepts it.
  typedef struct {
    bit    pinned;
    word_t count;
  } pinned_count_t;

  localparam int NUM_ROWS     = 21;
  localparam int RANDOM_ITEMS = 80;
  localparam int DRAIN_CYCLES = 200;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_stall_o;
  word_t limit_n_i;
  word_t modulus_m_i;
  logic  out_valid_o;
  logic  out_stall_i;
  word_t coprime_count_o;

  int unsigned     in_idle_pct;
  int unsigned     out_idle_pct;
  word_t           pending_counts [$];
  pinned_count_t   pinned_counts [$];
  longint unsigned cycle_count      = 0;
  longint unsigned cycle_budget     = 0;
  int unsigned     error_count      = 0;
  int unsigned     counts_checked   = 0;
  int unsigned     widest_prime_set = 0;

  int unsigned small_primes [25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                     43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

  // Directed rows: extremes of both fields and the special moduli.
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{32'd0,          32'd1,          1'b1, 32'd0},          // limit zero
    '{32'hFFFF_FFFF,  32'd1,          1'b1, 32'hFFFF_FFFF},  // modulus one, top limit
    '{32'd1000,       32'd1,          1'b1, 32'd1000},
    '{32'd12345,      32'd0,          1'b1, 32'd12345},      // modulus zero acts as one
    '{32'd0,          32'hFFFF_FFFF,  1'b1, 32'd0},
    '{32'd1,          32'hFFFF_FFFF,  1'b1, 32'd1},
    '{32'd10,         32'd2,          1'b1, 32'd5},
    '{32'hFFFF_FFFF,  32'd2,          1'b1, 32'h8000_0000},
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, 32'd0},
    '{32'hFFFF_FFFF,  32'h8000_0000,  1'b1, 32'h8000_0000},
    '{32'hFFFF_FFFF,  32'd223092870,  1'b0, 32'd0},          // nine distinct primes
    '{32'hFFFF_FFFF,  32'd4238764530, 1'b0, 32'd0},          // nine primes, top bit set
    '{32'd30,         32'd30,         1'b1, 32'd8},
    '{32'd100,        32'd97,         1'b1, 32'd99},
    '{32'h5A5A_5A5A,  32'd65537,      1'b0, 32'd0},
    '{32'd1000000,    32'd2000006,    1'b0, 32'd0},          // large prime cofactor
    '{32'hFFFF_FFFF,  32'd3486784401, 1'b1, 32'hAAAA_AAAA},  // one prime, high power
    '{32'hAAAA_AAAA,  32'h5555_5555,  1'b0, 32'd0},
    '{32'd7,          32'hFFFF_FFFC,  1'b0, 32'd0},
    '{32'h7FFF_FFFF,  32'd6,          1'b0, 32'd0},
    '{32'd1,          32'd1,          1'b1, 32'd1}
  };

  coprime_count_inclusion_exclusion dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .limit_n_i       (limit_n_i),
    .modulus_m_i     (modulus_m_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .coprime_count_o (coprime_count_o)
  );

  // Count of 1..n coprime to m. Also returns a loose cycle cost for the item
  // and the number of distinct primes found.
  function automatic word_t count_coprimes(input word_t n, input word_t m,
                                           output longint unsigned cost_cycles,
                                           output int unsigned prime_count);
    longint unsigned primes [ccie_pkg::MAX_DISTINCT_PRIMES];
    longint unsigned rest;
    longint unsigned d;
    longint unsigned prod;
    longint          acc;
    int unsigned     divisions;
    int unsigned     subset;
    int unsigned     i;
    bit              odd;
    rest        = m;
    prime_count = 0;
    divisions   = 0;
    // Trial division up to the root of what is left, removing each prime fully.
    for (d = 2; d * d <= rest; d++) begin
      divisions++;
      if (rest % d == 0) begin
        if (prime_count < ccie_pkg::MAX_DISTINCT_PRIMES) begin
          primes[prime_count] = d;
          prime_count++;
        end
        while (rest % d == 0) begin
          rest = rest / d;
          divisions++;
        end
      end
    end
    if (rest > 1 && prime_count < ccie_pkg::MAX_DISTINCT_PRIMES) begin
      primes[prime_count] = rest;
      prime_count++;
    end
    // Alternating sum over every non-empty subset of the primes.
    acc = longint'({32'd0, n});
    for (subset = 1; subset < (32'd1 << prime_count); subset++) begin
      prod = 1;
      odd  = 1'b0;
      for (i = 0; i < prime_count; i++) begin
        if (subset[i]) begin
          odd  = ~odd;
          prod = prod * primes[i];
        end
      end
      if (odd) begin
        acc = acc - longint'({32'd0, n} / prod);
      end else begin
        acc = acc + longint'({32'd0, n} / prod);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    cost_cycles = 40 * longint'(divisions) + 50 * (longint'(1) << prime_count) + 200;
    return acc[ccie_pkg::DATA_W-1:0];
  endfunction

  // Moduli are mostly smooth so that trial division stays short; some carry a
  // 16-bit cofactor, some have the top bit forced, some are powers of two.
  function automatic word_t pick_modulus();
    longint unsigned prod;
    longint unsigned p;
    int unsigned     factors;
    int unsigned     mode;
    prod    = 1;
    mode    = $urandom_range(0, 9);
    factors = (mode >= 5) ? $urandom_range(1, 3) : $urandom_range(1, 9);
    repeat (factors) begin
      p = small_primes[$urandom_range(0, 24)];
      repeat ($urandom_range(1, 3)) begin
        if (prod * p < 64'h1_0000_0000) begin
          prod = prod * p;
        end
      end
    end
    case (mode)
      5, 6: begin
        p = $urandom_range(2, 65535);
        if (prod * p < 64'h1_0000_0000) begin
          prod = prod * p;
        end
      end
      7: prod = $urandom_range(1, 65535);
      8: begin
        while (prod < 64'h8000_0000) begin
          prod = prod * 2;
        end
      end
      9: prod = longint'(1) << $urandom_range(0, 31);
      default: ;
    endcase
    return prod[ccie_pkg::DATA_W-1:0];
  endfunction

  // Limits: small values, values near the top, and full-width random.
  function automatic word_t pick_limit();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 64);
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Offer one item at the falling edge and hold it until the block takes it.
  task automatic send_item(input word_t n, input word_t m, input bit pinned,
                           input word_t count);
    pinned_count_t pin;
    pin.pinned = pinned;
    pin.count  = count;
    pinned_counts.insert(pinned_counts.size(), pin);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    limit_n_i   <= n;
    modulus_m_i <= m;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver stalls at random.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_idle_pct);
  end

  // Watchdog: the budget grows with the work of every accepted item.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 4 * cycle_budget + 20000) begin
      $display("Timeout after %0d cycles with %0d counts outstanding.",
               cycle_count, pending_counts.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Predict on every accepted item and compare every accepted result.
  always @(posedge clk_i) begin : scoreboard
    word_t           predicted;
    word_t           expected;
    longint unsigned cost;
    int unsigned     primes_found;
    pinned_count_t   pin;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predicted    = count_coprimes(limit_n_i, modulus_m_i, cost, primes_found);
      cycle_budget = cycle_budget + cost;
      if (primes_found > widest_prime_set) begin
        widest_prime_set = primes_found;
      end
      pin = pinned_counts.pop_front();
      pending_counts.insert(pending_counts.size(), pin.pinned ? pin.count : predicted);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_counts.size() == 0) begin
        $error("coprime_count result with no item outstanding: actual %0d",
               coprime_count_o);
        error_count++;
      end else begin
        expected = pending_counts.pop_front();
        counts_checked++;
        if (coprime_count_o !== expected) begin
          $error("coprime_count mismatch: expected %0d, actual %0d",
                 expected, coprime_count_o);
          error_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, three random phases, drain.
  initial begin : stimulus
    int r;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    limit_n_i    = '0;
    modulus_m_i  = '0;
    out_stall_i  = 1'b0;
    in_idle_pct  = 17;
    out_idle_pct = 54;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[k]) begin
      send_item(directed_rows[k].limit_n, directed_rows[k].modulus_m,
                directed_rows[k].pinned, directed_rows[k].count);
    end

    for (r = 0; r < RANDOM_ITEMS; r++) begin
      if (r == RANDOM_ITEMS / 3) begin
        in_idle_pct  = 54;
        out_idle_pct = 17;
      end
      if (r == 2 * RANDOM_ITEMS / 3) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      send_item(pick_limit(), pick_modulus(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    // Wait for every count, then watch a while for stray results.
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d table rows and %0d random items; %0d counts compared.",
             NUM_ROWS, RANDOM_ITEMS, counts_checked);
    $display("Moduli reached %0d distinct primes; both fields hit their 32-bit extremes.",
             widest_prime_set);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ccie_pkg.sv
rtl/ccie_div.sv
rtl/coprime_count_inclusion_exclusion.sv
verif/coprime_count_inclusion_exclusion_tb.sv
